[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SMBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SMBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/smbs_pkg.sv]
package smbs_pkg;

    localparam int BOUND_BITS     = 15;
    localparam int SIZE_BITS      = 12;
    localparam int MODE_BITS      = 2;
    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_INDEX_BITS = 3;

    // w / 12 as (w * 2731) >> 15, exact for every 12-bit w
    localparam int SHRINK_BITS  = 9;
    localparam int SHRINK_MUL   = 2731;
    localparam int SHRINK_SHIFT = 15;
    localparam int PROD_BITS    = 26;

    localparam logic [MODE_BITS-1:0] MODE_STOP   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_WRAP   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BOUNCE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_DIE    = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BOUND_LEFT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOUND_TOP     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOUND_RIGHT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOUND_BOTTOM  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_MODE     = 3'd6;

    localparam logic signed [BOUND_BITS-1:0] RST_BOUND_LEFT   = 15'sd0;
    localparam logic signed [BOUND_BITS-1:0] RST_BOUND_TOP    = 15'sd0;
    localparam logic signed [BOUND_BITS-1:0] RST_BOUND_RIGHT  = 15'sd640;
    localparam logic signed [BOUND_BITS-1:0] RST_BOUND_BOTTOM = 15'sd480;
    localparam logic [SIZE_BITS-1:0]         RST_SPRITE_SIZE  = 12'd32;
    localparam logic [SHRINK_BITS-1:0]       RST_SHRINK       = 9'd2;

    typedef struct packed {
        logic signed [BOUND_BITS-1:0] bound_left;
        logic signed [BOUND_BITS-1:0] bound_top;
        logic signed [BOUND_BITS-1:0] bound_right;
        logic signed [BOUND_BITS-1:0] bound_bottom;
        logic [SIZE_BITS-1:0]         sprite_width;
        logic [SIZE_BITS-1:0]         sprite_height;
        logic [SHRINK_BITS-1:0]       shrink_w;
        logic [SHRINK_BITS-1:0]       shrink_h;
        logic [MODE_BITS-1:0]         edge_mode;
    } cfg_t;

endpackage

[src/sprite_motion_bounds_step_top.sv]
// Channel   Direction  Handshake            Payload
// config    in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_stall  cmd, load_x, load_y, load_vx, load_vy
// out       out        out_valid / out_stall pos_x, pos_y, vel_x, vel_y, kill, coll_*
//
// One item per cycle unless stalled; a result is out in the cycle after its transfer.
// The position/velocity registers feed back through one pass of add, clamp and select.
// in_stall is high only while a finished result is held by out_stall.
// Reset clears position, velocity and the output valid, and loads the register defaults.
module sprite_motion_bounds_step_top
    import smbs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VEL_BITS   = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic signed [COORD_BITS-1:0]  load_x,
    input  logic signed [COORD_BITS-1:0]  load_y,
    input  logic signed [VEL_BITS-1:0]    load_vx,
    input  logic signed [VEL_BITS-1:0]    load_vy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS-1:0]  pos_x,
    output logic signed [COORD_BITS-1:0]  pos_y,
    output logic signed [VEL_BITS-1:0]    vel_x,
    output logic signed [VEL_BITS-1:0]    vel_y,
    output logic                          kill,
    output logic signed [COORD_BITS-1:0]  coll_left,
    output logic signed [COORD_BITS-1:0]  coll_top,
    output logic signed [COORD_BITS-1:0]  coll_right,
    output logic signed [COORD_BITS-1:0]  coll_bottom
);

    cfg_t cfg_reg;
    logic [PROD_BITS-1:0] shrink_prod;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [VEL_BITS-1:0]   cur_vx_reg, cur_vy_reg;
    logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next;
    logic signed [VEL_BITS-1:0]   cur_vx_next, cur_vy_next;
    logic                         kill_next, kill_reg;
    logic signed [COORD_BITS-1:0] cl_next, ct_next, cr_next, cb_next;
    logic signed [COORD_BITS-1:0] cl_reg, ct_reg, cr_reg, cb_reg;
    logic                         out_valid_reg;
    logic                         in_xfer;

    // w / 12 by reciprocal, worked out once when the size is written
    assign shrink_prod = PROD_BITS'(cfg_data[SIZE_BITS-1:0]) * PROD_BITS'(SHRINK_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bound_left    <= RST_BOUND_LEFT;
            cfg_reg.bound_top     <= RST_BOUND_TOP;
            cfg_reg.bound_right   <= RST_BOUND_RIGHT;
            cfg_reg.bound_bottom  <= RST_BOUND_BOTTOM;
            cfg_reg.sprite_width  <= RST_SPRITE_SIZE;
            cfg_reg.sprite_height <= RST_SPRITE_SIZE;
            cfg_reg.shrink_w      <= RST_SHRINK;
            cfg_reg.shrink_h      <= RST_SHRINK;
            cfg_reg.edge_mode     <= MODE_STOP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOUND_LEFT:   cfg_reg.bound_left   <= cfg_data;
                REG_BOUND_TOP:    cfg_reg.bound_top    <= cfg_data;
                REG_BOUND_RIGHT:  cfg_reg.bound_right  <= cfg_data;
                REG_BOUND_BOTTOM: cfg_reg.bound_bottom <= cfg_data;
                REG_SPRITE_WIDTH:
                begin
                    cfg_reg.sprite_width <= cfg_data[SIZE_BITS-1:0];
                    cfg_reg.shrink_w <= shrink_prod[SHRINK_SHIFT +: SHRINK_BITS];
                end
                REG_SPRITE_HEIGHT:
                begin
                    cfg_reg.sprite_height <= cfg_data[SIZE_BITS-1:0];
                    cfg_reg.shrink_h <= shrink_prod[SHRINK_SHIFT +: SHRINK_BITS];
                end
                REG_EDGE_MODE:    cfg_reg.edge_mode    <= cfg_data[MODE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    smbs_step #(
        .COORD_BITS (COORD_BITS),
        .VEL_BITS   (VEL_BITS)
    ) u_step (
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .load_x      (load_x),
        .load_y      (load_y),
        .load_vx     (load_vx),
        .load_vy     (load_vy),
        .cur_x       (cur_x_reg),
        .cur_y       (cur_y_reg),
        .cur_vx      (cur_vx_reg),
        .cur_vy      (cur_vy_reg),
        .next_x      (cur_x_next),
        .next_y      (cur_y_next),
        .next_vx     (cur_vx_next),
        .next_vy     (cur_vy_next),
        .kill        (kill_next),
        .coll_left   (cl_next),
        .coll_top    (ct_next),
        .coll_right  (cr_next),
        .coll_bottom (cb_next)
    );

    // take a new item whenever the result register is empty or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_vx_reg    <= '0;
            cur_vy_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_vx_reg    <= cur_vx_next;
            cur_vy_reg    <= cur_vy_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kill_reg <= kill_next;
            cl_reg   <= cl_next;
            ct_reg   <= ct_next;
            cr_reg   <= cr_next;
            cb_reg   <= cb_next;
        end
    end

    // the state registers double as the position and velocity outputs
    assign out_valid   = out_valid_reg;
    assign pos_x       = cur_x_reg;
    assign pos_y       = cur_y_reg;
    assign vel_x       = cur_vx_reg;
    assign vel_y       = cur_vy_reg;
    assign kill        = kill_reg;
    assign coll_left   = cl_reg;
    assign coll_top    = ct_reg;
    assign coll_right  = cr_reg;
    assign coll_bottom = cb_reg;

endmodule

[src/smbs_step.sv]
module smbs_step
    import smbs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VEL_BITS   = 12
)
(
    input  cfg_t                         cfg,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] load_x,
    input  logic signed [COORD_BITS-1:0] load_y,
    input  logic signed [VEL_BITS-1:0]   load_vx,
    input  logic signed [VEL_BITS-1:0]   load_vy,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic signed [VEL_BITS-1:0]   cur_vx,
    input  logic signed [VEL_BITS-1:0]   cur_vy,
    output logic signed [COORD_BITS-1:0] next_x,
    output logic signed [COORD_BITS-1:0] next_y,
    output logic signed [VEL_BITS-1:0]   next_vx,
    output logic signed [VEL_BITS-1:0]   next_vy,
    output logic                         kill,
    output logic signed [COORD_BITS-1:0] coll_left,
    output logic signed [COORD_BITS-1:0] coll_top,
    output logic signed [COORD_BITS-1:0] coll_right,
    output logic signed [COORD_BITS-1:0] coll_bottom
);

    localparam int W = (COORD_BITS > 16) ? COORD_BITS + 2 : 18;
    localparam logic signed [W-1:0] CMAX = W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [W-1:0] CMIN = W'(-(64'sd1 <<< (COORD_BITS - 1)));
    localparam logic signed [VEL_BITS-1:0] VMIN = {1'b1, {(VEL_BITS-1){1'b0}}};
    localparam logic signed [VEL_BITS-1:0] VMAX = ~VMIN;

    function automatic logic signed [W-1:0] csat(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        if (v > CMAX)
            r = CMAX;
        else if (v < CMIN)
            r = CMIN;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [VEL_BITS-1:0] vneg(input logic signed [VEL_BITS-1:0] v);
        return (v == VMIN) ? VMAX : -v;
    endfunction

    logic signed [W-1:0] cx, cy, vxw, vyw;
    logic signed [W-1:0] bl, bt, br, bb, ww, hw, sw, sh;
    logic signed [W-1:0] sx, sy, sxw, syh;
    logic signed [W-1:0] nx, ny;
    logic signed [VEL_BITS-1:0] nvx, nvy;
    logic x_lo, x_hi, y_lo, y_hi;
    logic x_out_lo, x_out_hi, y_out_lo, y_out_hi;
    logic k;

    assign cx  = W'(cur_x);
    assign cy  = W'(cur_y);
    assign vxw = W'(cur_vx);
    assign vyw = W'(cur_vy);
    assign bl  = W'($signed(cfg.bound_left));
    assign bt  = W'($signed(cfg.bound_top));
    assign br  = W'($signed(cfg.bound_right));
    assign bb  = W'($signed(cfg.bound_bottom));
    assign ww  = W'(cfg.sprite_width);
    assign hw  = W'(cfg.sprite_height);
    assign sw  = W'(cfg.shrink_w);
    assign sh  = W'(cfg.shrink_h);

    assign sx  = csat(cx + vxw);
    assign sy  = csat(cy + vyw);
    assign sxw = sx + ww;
    assign syh = sy + hw;

    // clamp tests for stop and bounce
    assign x_lo = sx < bl;
    assign x_hi = sxw > br;
    assign y_lo = sy < bt;
    assign y_hi = syh > bb;

    // fully-outside tests for wrap and die
    assign x_out_lo = sxw < bl;
    assign x_out_hi = sx > br;
    assign y_out_lo = syh < bt;
    assign y_out_hi = sy > bb;

    always_comb
    begin
        nx  = sx;
        ny  = sy;
        nvx = cur_vx;
        nvy = cur_vy;
        k   = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            nx  = W'(load_x);
            ny  = W'(load_y);
            nvx = load_vx;
            nvy = load_vy;
        end
        else
        begin
            case (cfg.edge_mode)
                MODE_BOUNCE:
                begin
                    if (x_lo)
                    begin
                        nx  = csat(bl);
                        nvx = vneg(cur_vx);
                    end
                    else if (x_hi)
                    begin
                        nx  = csat(br - ww);
                        nvx = vneg(cur_vx);
                    end
                    if (y_lo)
                    begin
                        ny  = csat(bt);
                        nvy = vneg(cur_vy);
                    end
                    else if (y_hi)
                    begin
                        ny  = csat(bb - hw);
                        nvy = vneg(cur_vy);
                    end
                end
                MODE_WRAP:
                begin
                    if (x_out_lo)
                        nx = csat(br);
                    else if (x_out_hi)
                        nx = csat(bl - ww);
                    if (y_out_lo)
                        ny = csat(bb);
                    else if (y_out_hi)
                        ny = csat(bt - hw);
                end
                MODE_DIE:
                begin
                    // hold the state on a kill
                    if (x_out_lo || x_out_hi || y_out_lo || y_out_hi)
                    begin
                        k  = 1'b1;
                        nx = cx;
                        ny = cy;
                    end
                end
                default:
                begin
                    if (x_lo)
                        nx = csat(bl);
                    else if (x_hi)
                        nx = csat(br - ww);
                    if (y_lo)
                        ny = csat(bt);
                    else if (y_hi)
                        ny = csat(bb - hw);
                    if (x_lo || x_hi || y_lo || y_hi)
                    begin
                        nvx = '0;
                        nvy = '0;
                    end
                end
            endcase
        end
    end

    assign next_x  = COORD_BITS'(nx);
    assign next_y  = COORD_BITS'(ny);
    assign next_vx = nvx;
    assign next_vy = nvy;
    assign kill    = k;

    assign coll_left   = COORD_BITS'(csat(nx + sw));
    assign coll_top    = COORD_BITS'(csat(ny + sh));
    assign coll_right  = COORD_BITS'(csat(nx + ww - sw));
    assign coll_bottom = COORD_BITS'(csat(ny + hw - sh));

endmodule

[src/smbs_checker.sv]
`include "assert_macros.svh"

module smbs_checker
    import smbs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VEL_BITS   = 12
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         cmd,
    input logic signed [COORD_BITS-1:0] load_x,
    input logic signed [VEL_BITS-1:0]   load_vx,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [COORD_BITS-1:0] pos_x,
    input logic signed [VEL_BITS-1:0]   vel_x,
    input logic                         kill
);

    // a load transfer comes back with the loaded x position and x velocity and no kill
    property p_load_echo;
        in_valid && !in_stall && cmd == CMD_LOAD |=>
            pos_x == $past(load_x) && vel_x == $past(load_vx) && !kill;
    endproperty

    `SMBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    `SMBS_ASSERT(a_xfer_result, in_valid && !in_stall |=> out_valid, "transfer gave no result")

    `SMBS_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with room free")

    `SMBS_ASSERT(a_load_echo, p_load_echo, "load result does not match loaded values")

endmodule

bind sprite_motion_bounds_step_top smbs_checker #(
    .COORD_BITS (COORD_BITS),
    .VEL_BITS   (VEL_BITS)
) u_checker (.*);

[tb/tb_sprite_motion_bounds_step_top.sv]
module tb_sprite_motion_bounds_step_top;
    import smbs_pkg::*;

    localparam int COORD_BITS     = 16;
    localparam int VEL_BITS       = 12;
    localparam int SHRINK_DIV     = 12;
    localparam int ITEMS_PER_PHASE = 420;

    typedef struct {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [VEL_BITS-1:0]   vx;
        logic signed [VEL_BITS-1:0]   vy;
    } move_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [VEL_BITS-1:0]   vel_x;
        logic signed [VEL_BITS-1:0]   vel_y;
        logic                         kill;
        logic signed [COORD_BITS-1:0] coll_left;
        logic signed [COORD_BITS-1:0] coll_top;
        logic signed [COORD_BITS-1:0] coll_right;
        logic signed [COORD_BITS-1:0] coll_bottom;
    } sprite_out_t;

    typedef struct {
        int                   left;
        int                   top;
        int                   right;
        int                   bottom;
        int                   width;
        int                   height;
        logic [MODE_BITS-1:0] mode;
    } bounds_cfg_t;

    typedef struct {
        int          setting;
        move_t       mv;
        bit          pinned;
        sprite_out_t want;
    } probe_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  load_x;
    logic signed [COORD_BITS-1:0]  load_y;
    logic signed [VEL_BITS-1:0]    load_vx;
    logic signed [VEL_BITS-1:0]    load_vy;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [VEL_BITS-1:0]    vel_x;
    logic signed [VEL_BITS-1:0]    vel_y;
    logic                          kill;
    logic signed [COORD_BITS-1:0]  coll_left;
    logic signed [COORD_BITS-1:0]  coll_top;
    logic signed [COORD_BITS-1:0]  coll_right;
    logic signed [COORD_BITS-1:0]  coll_bottom;

    // Fixed expectation that travels with the item on the input channel
    logic        pin_valid;
    sprite_out_t pin_want;
    sprite_out_t no_pin = '{default: 0};

    // Predictor copy of the registers and the sprite state
    logic signed [BOUND_BITS-1:0] cfg_left   = RST_BOUND_LEFT;
    logic signed [BOUND_BITS-1:0] cfg_top    = RST_BOUND_TOP;
    logic signed [BOUND_BITS-1:0] cfg_right  = RST_BOUND_RIGHT;
    logic signed [BOUND_BITS-1:0] cfg_bottom = RST_BOUND_BOTTOM;
    logic [SIZE_BITS-1:0]         cfg_width  = RST_SPRITE_SIZE;
    logic [SIZE_BITS-1:0]         cfg_height = RST_SPRITE_SIZE;
    logic [MODE_BITS-1:0]         cfg_mode   = MODE_STOP;
    logic signed [COORD_BITS-1:0] cur_x  = '0;
    logic signed [COORD_BITS-1:0] cur_y  = '0;
    logic signed [VEL_BITS-1:0]   cur_vx = '0;
    logic signed [VEL_BITS-1:0]   cur_vy = '0;

    sprite_out_t pending_sprites [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 37;
    int          recv_stall_pct = 52;

    bounds_cfg_t cfg_sets [8] = '{
        '{0, 0, 640, 480, 32, 32, MODE_STOP},
        '{0, 0, 640, 480, 32, 32, MODE_WRAP},
        '{0, 0, 640, 480, 32, 32, MODE_BOUNCE},
        '{0, 0, 640, 480, 32, 32, MODE_DIE},
        '{-16384, -16384, 16383, 16383, 4095, 4095, MODE_BOUNCE},
        '{500, 300, 100, -300, 0, 0, MODE_STOP},
        '{-16384, -16384, 16383, 16383, 1, 1, MODE_WRAP},
        '{16383, 16383, -16384, -16384, 4095, 4095, MODE_DIE}
    };

    probe_t directed_rows [27] = '{
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0, 2, 2, 30, 30}},
        '{-1, '{CMD_LOAD, 100, 50, 3, -4}, 1'b1,
            '{100, 50, 3, -4, 1'b0, 102, 52, 130, 80}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{-1, '{CMD_LOAD, 32767, -32768, 2047, -2048}, 1'b1,
            '{32767, -32768, 2047, -2048, 1'b0, 32767, -32766, 32767, -32738}},
        '{-1, '{CMD_TICK, -1, -1, -1, -1}, 1'b0, '{default: 0}},
        '{-1, '{CMD_LOAD, -32768, 32767, -2048, 2047}, 1'b1,
            '{-32768, 32767, -2048, 2047, 1'b0, -32766, 32767, -32738, 32767}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{1, '{CMD_LOAD, 700, 10, 5, 0}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{-1, '{CMD_LOAD, -40, -40, -1, -1}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{2, '{CMD_LOAD, 630, 5, 10, -2048}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{-1, '{CMD_LOAD, 5, 470, -2048, 7}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{3, '{CMD_LOAD, 700, 0, 1, 0}, 1'b1,
            '{700, 0, 1, 0, 1'b0, 702, 2, 730, 30}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b1, '{700, 0, 1, 0, 1'b1, 702, 2, 730, 30}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b1, '{700, 0, 1, 0, 1'b1, 702, 2, 730, 30}},
        '{-1, '{CMD_LOAD, 100, 100, 1, 1}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{4, '{CMD_LOAD, 32767, 32767, 2047, 2047}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{5, '{CMD_LOAD, 200, 0, 1, 1}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{7, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{6, '{CMD_LOAD, -16386, 16383, -1, 1}, 1'b0, '{default: 0}},
        '{-1, '{CMD_TICK, 0, 0, 0, 0}, 1'b0, '{default: 0}}
    };

    sprite_motion_bounds_step_top #(
        .COORD_BITS(COORD_BITS),
        .VEL_BITS  (VEL_BITS)
    ) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat_to(input longint v, input int bits);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (bits - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
            return hi_lim;
        if (v < lo_lim)
            return lo_lim;
        return v;
    endfunction

    function automatic sprite_out_t step_sprite(input move_t m);
        longint      w, h, bl, bt, br, bb;
        longint      nx, ny, vx, vy;
        logic        hit;
        sprite_out_t r;
        w   = longint'(cfg_width);
        h   = longint'(cfg_height);
        bl  = longint'(cfg_left);
        bt  = longint'(cfg_top);
        br  = longint'(cfg_right);
        bb  = longint'(cfg_bottom);
        hit = 1'b0;
        if (m.cmd == CMD_LOAD)
        begin
            cur_x  = m.x;
            cur_y  = m.y;
            cur_vx = m.vx;
            cur_vy = m.vy;
        end
        else
        begin
            nx = sat_to(longint'(cur_x) + longint'(cur_vx), COORD_BITS);
            ny = sat_to(longint'(cur_y) + longint'(cur_vy), COORD_BITS);
            vx = longint'(cur_vx);
            vy = longint'(cur_vy);
            case (cfg_mode)
                MODE_BOUNCE:
                begin
                    if (nx < bl)
                    begin
                        nx = sat_to(bl, COORD_BITS);
                        vx = sat_to(-vx, VEL_BITS);
                    end
                    else if (nx + w > br)
                    begin
                        nx = sat_to(br - w, COORD_BITS);
                        vx = sat_to(-vx, VEL_BITS);
                    end
                    if (ny < bt)
                    begin
                        ny = sat_to(bt, COORD_BITS);
                        vy = sat_to(-vy, VEL_BITS);
                    end
                    else if (ny + h > bb)
                    begin
                        ny = sat_to(bb - h, COORD_BITS);
                        vy = sat_to(-vy, VEL_BITS);
                    end
                end
                MODE_WRAP:
                begin
                    if (nx + w < bl)
                        nx = sat_to(br, COORD_BITS);
                    else if (nx > br)
                        nx = sat_to(bl - w, COORD_BITS);
                    if (ny + h < bt)
                        ny = sat_to(bb, COORD_BITS);
                    else if (ny > bb)
                        ny = sat_to(bt - h, COORD_BITS);
                end
                MODE_DIE:
                    hit = (nx + w < bl) || (nx > br) || (ny + h < bt) || (ny > bb);
                default:
                begin
                    // any clamp stops the sprite on both axes
                    if (nx < bl)
                    begin
                        vx = 0;
                        vy = 0;
                        nx = sat_to(bl, COORD_BITS);
                    end
                    else if (nx + w > br)
                    begin
                        vx = 0;
                        vy = 0;
                        nx = sat_to(br - w, COORD_BITS);
                    end
                    if (ny < bt)
                    begin
                        vx = 0;
                        vy = 0;
                        ny = sat_to(bt, COORD_BITS);
                    end
                    else if (ny + h > bb)
                    begin
                        vx = 0;
                        vy = 0;
                        ny = sat_to(bb - h, COORD_BITS);
                    end
                end
            endcase
            // a kill leaves the sprite where it was
            if (!hit)
            begin
                cur_x  = COORD_BITS'(nx);
                cur_y  = COORD_BITS'(ny);
                cur_vx = VEL_BITS'(vx);
                cur_vy = VEL_BITS'(vy);
            end
        end
        r.pos_x       = cur_x;
        r.pos_y       = cur_y;
        r.vel_x       = cur_vx;
        r.vel_y       = cur_vy;
        r.kill        = hit;
        r.coll_left   = COORD_BITS'(sat_to(longint'(cur_x) + w / SHRINK_DIV, COORD_BITS));
        r.coll_top    = COORD_BITS'(sat_to(longint'(cur_y) + h / SHRINK_DIV, COORD_BITS));
        r.coll_right  = COORD_BITS'(sat_to(longint'(cur_x) + w - w / SHRINK_DIV,
                                           COORD_BITS));
        r.coll_bottom = COORD_BITS'(sat_to(longint'(cur_y) + h - h / SHRINK_DIV,
                                           COORD_BITS));
        return r;
    endfunction

    function automatic bounds_cfg_t random_bounds();
        bounds_cfg_t s;
        case ($urandom_range(9))
            0:
            begin
                s.left   = int'($urandom_range(32767)) - 16384;
                s.top    = int'($urandom_range(32767)) - 16384;
                s.right  = int'($urandom_range(32767)) - 16384;
                s.bottom = int'($urandom_range(32767)) - 16384;
                s.width  = int'($urandom_range(4095, 1));
                s.height = int'($urandom_range(4095, 1));
            end
            1:
            begin
                s.left   = $urandom_range(1) ? 16383 : -16384;
                s.top    = $urandom_range(1) ? 16383 : -16384;
                s.right  = $urandom_range(1) ? 16383 : -16384;
                s.bottom = $urandom_range(1) ? 16383 : -16384;
                s.width  = $urandom_range(1) ? 4095 : 1;
                s.height = $urandom_range(1) ? 4095 : 1;
            end
            default:
            begin
                s.left   = int'($urandom_range(2000)) - 1000;
                s.top    = int'($urandom_range(2000)) - 1000;
                s.right  = s.left + int'($urandom_range(1500, 100));
                s.bottom = s.top + int'($urandom_range(1500, 100));
                s.width  = int'($urandom_range(64, 1));
                s.height = int'($urandom_range(64, 1));
            end
        endcase
        s.mode = MODE_BITS'($urandom_range(3));
        return s;
    endfunction

    function automatic longint near_span(input int a, input int b);
        longint lo;
        longint span;
        lo   = (a < b) ? a : b;
        span = (a < b) ? b - a : a - b;
        return sat_to(lo - 96 + longint'($urandom_range(32'(span) + 192)), COORD_BITS);
    endfunction

    // Mostly ticks; most loads land around the allowed area, often with modest speed
    function automatic move_t random_move(input bounds_cfg_t s, input bit want_load);
        move_t m;
        m.x   = COORD_BITS'($urandom);
        m.y   = COORD_BITS'($urandom);
        m.vx  = VEL_BITS'($urandom);
        m.vy  = VEL_BITS'($urandom);
        m.cmd = (want_load || $urandom_range(99) < 22) ? CMD_LOAD : CMD_TICK;
        if (m.cmd == CMD_LOAD && $urandom_range(99) < 75)
        begin
            m.x = COORD_BITS'(near_span(s.left, s.right));
            m.y = COORD_BITS'(near_span(s.top, s.bottom));
            if ($urandom_range(3) != 0)
            begin
                m.vx = VEL_BITS'(int'($urandom_range(96)) - 48);
                m.vy = VEL_BITS'(int'($urandom_range(96)) - 48);
            end
        end
        return m;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_item(input move_t m, input bit pinned, input sprite_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= m.cmd;
        load_x    <= m.x;
        load_y    <= m.y;
        load_vx   <= m.vx;
        load_vy   <= m.vy;
        pin_valid <= pinned;
        pin_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold the sender until every result is back, then let the block go quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sprites.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
    endtask

    task automatic apply_bounds(input bounds_cfg_t s);
        drain();
        write_reg(REG_BOUND_LEFT, s.left);
        write_reg(REG_BOUND_TOP, s.top);
        write_reg(REG_BOUND_RIGHT, s.right);
        write_reg(REG_BOUND_BOTTOM, s.bottom);
        write_reg(REG_SPRITE_WIDTH, s.width);
        write_reg(REG_SPRITE_HEIGHT, s.height);
        write_reg(REG_EDGE_MODE, int'(s.mode));
        cfg_we     <= 1'b0;
        cfg_left   = BOUND_BITS'(s.left);
        cfg_top    = BOUND_BITS'(s.top);
        cfg_right  = BOUND_BITS'(s.right);
        cfg_bottom = BOUND_BITS'(s.bottom);
        cfg_width  = SIZE_BITS'(s.width);
        cfg_height = SIZE_BITS'(s.height);
        cfg_mode   = s.mode;
        @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Check finished results first, then predict the transfer taken at this edge
    always @(posedge clk)
    begin : scoreboard
        sprite_out_t want;
        move_t       taken;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_sprites.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_sprites.pop_front();
                    check_field("pos_x", want.pos_x, pos_x);
                    check_field("pos_y", want.pos_y, pos_y);
                    check_field("vel_x", want.vel_x, vel_x);
                    check_field("vel_y", want.vel_y, vel_y);
                    check_field("kill", want.kill, kill);
                    check_field("coll_left", want.coll_left, coll_left);
                    check_field("coll_top", want.coll_top, coll_top);
                    check_field("coll_right", want.coll_right, coll_right);
                    check_field("coll_bottom", want.coll_bottom, coll_bottom);
                end
            end
            if (in_valid && !in_stall)
            begin
                taken = '{cmd, load_x, load_y, load_vx, load_vy};
                want  = step_sprite(taken);
                pending_sprites.push_back(pin_valid ? pin_want : want);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        bounds_cfg_t s;
        int          sent;
        int          seg;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= CMD_TICK;
        load_x    <= '0;
        load_y    <= '0;
        load_vx   <= '0;
        load_vy   <= '0;
        pin_valid <= 1'b0;
        pin_want  <= no_pin;
        out_stall <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].setting >= 0)
                apply_bounds(cfg_sets[directed_rows[i].setting]);
            push_item(directed_rows[i].mv, directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 52;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 37;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                s = random_bounds();
                apply_bounds(s);
                seg = int'($urandom_range(60, 20));
                // start each stretch from a fresh load under the new bounds
                for (int k = 0; k < seg; k++)
                begin
                    push_item(random_move(s, k == 0), 1'b0, no_pin);
                    sent++;
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
